// ===== hw/rtl/assert_macros.svh =====
// assertion macros included by the executor top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`endif
`endif

// ===== hw/rtl/sie_pkg.sv =====
// constants, opcodes, pipeline types and helpers of the instruction executor
package sie_pkg;

   localparam int MEM_WORDS  = 4096;
   localparam int NUM_REGS   = 32;
   localparam int PROG_DEPTH = 1024;

   localparam int MEM_AW = $clog2(MEM_WORDS);
   localparam int REG_AW = $clog2(NUM_REGS);

   localparam int OPC_W  = 4;
   localparam int RIDX_W = 5;
   localparam int DATA_W = 32;
   localparam int TGT_W  = 10;
   localparam int PC_W   = 11;

   localparam logic [OPC_W-1:0] OP_NOP  = 4'd0;
   localparam logic [OPC_W-1:0] OP_SUB  = 4'd1;
   localparam logic [OPC_W-1:0] OP_ADDI = 4'd2;
   localparam logic [OPC_W-1:0] OP_SUBI = 4'd3;
   localparam logic [OPC_W-1:0] OP_LI   = 4'd4;
   localparam logic [OPC_W-1:0] OP_MV   = 4'd5;
   localparam logic [OPC_W-1:0] OP_SLT  = 4'd6;
   localparam logic [OPC_W-1:0] OP_LW   = 4'd7;
   localparam logic [OPC_W-1:0] OP_SW   = 4'd8;
   localparam logic [OPC_W-1:0] OP_J    = 4'd9;
   localparam logic [OPC_W-1:0] OP_BLT  = 4'd10;
   localparam logic [OPC_W-1:0] OP_BGT  = 4'd11;
   localparam logic [OPC_W-1:0] OP_BGE  = 4'd12;
   localparam logic [OPC_W-1:0] OP_BNE  = 4'd13;
   localparam logic [OPC_W-1:0] OP_EXIT = 4'd14;

   // instruction held in the execute stage
   typedef struct packed {
      logic [OPC_W-1:0]  op;
      logic [RIDX_W-1:0] rd;
      logic [RIDX_W-1:0] ra;
      logic [RIDX_W-1:0] rb;
      logic [DATA_W-1:0] imm;
      logic [TGT_W-1:0]  tgt;
      logic              found;
      logic              a_ok;
      logic              b_ok;
   } item_type;

   // executed instruction waiting for load data and write-back
   typedef struct packed {
      logic              wr;
      logic [RIDX_W-1:0] rd;
      logic [DATA_W-1:0] val;
      logic              is_lw;
      logic              fault;
      logic              halt;
      logic [PC_W-1:0]   next_pc;
   } ex_type;

   // result beat
   typedef struct packed {
      logic [PC_W-1:0]   next_pc;
      logic              reg_written;
      logic [RIDX_W-1:0] written_reg;
      logic [DATA_W-1:0] written_value;
      logic              memory_fault;
      logic              halted;
   } out_type;

   function automatic logic [PC_W-1:0] clamp_pc(input logic [31:0] v);
      logic [31:0] c;
      c = (v > 32'(PROG_DEPTH)) ? 32'(PROG_DEPTH) : v;
      return c[PC_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/sie_req_if.sv =====
// instruction channel: valid, ready and the pre-decoded instruction fields
interface sie_req_if;
   logic                              valid;
   logic                              ready;
   logic [sie_pkg::OPC_W-1:0]         opcode;
   logic [sie_pkg::RIDX_W-1:0]        dest_reg;
   logic [sie_pkg::RIDX_W-1:0]        src_reg_a;
   logic [sie_pkg::RIDX_W-1:0]        src_reg_b;
   logic signed [sie_pkg::DATA_W-1:0] immediate;
   logic [sie_pkg::TGT_W-1:0]         target_pc;
   logic                              target_found;

   modport source (
      output valid, opcode, dest_reg, src_reg_a, src_reg_b, immediate, target_pc,
             target_found,
      input  ready
   );
   modport sink (
      input  valid, opcode, dest_reg, src_reg_a, src_reg_b, immediate, target_pc,
             target_found,
      output ready
   );
endinterface

// ===== hw/rtl/sie_rsp_if.sv =====
// result channel: valid, ready and the execution result fields
interface sie_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [sie_pkg::PC_W-1:0]          next_pc;
   logic                              reg_written;
   logic [sie_pkg::RIDX_W-1:0]        written_reg;
   logic signed [sie_pkg::DATA_W-1:0] written_value;
   logic                              memory_fault;
   logic                              halted;

   modport source (
      output valid, next_pc, reg_written, written_reg, written_value, memory_fault,
             halted,
      input  ready
   );
   modport sink (
      input  valid, next_pc, reg_written, written_reg, written_value, memory_fault,
             halted,
      output ready
   );
endinterface

// ===== hw/rtl/sie_ram.sv =====
// generic single-write, single-read synchronous ram with registered read
module sie_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // read during write to the same entry returns the old word
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ===== hw/rtl/small_isa_instruction_executor_top.sv =====
// top level of the instruction executor: execute, load/write-back and result stages
// the result beat becomes valid after the instruction has moved through the s1, s2 and out registers
// throughput: one instruction per cycle while rsp ready is high; register operands come
//   from two register-file ram copies forwarded from write-back; dependents never stall
// reset: pc and register valid bits clear at once; the data memory is then swept to
//   zero one word a cycle, all MEM_WORDS = 4096 words, with req ready held low
`include "assert_macros.svh"

module small_isa_instruction_executor_top (
   input logic        clock,
   input logic        reset,
   sie_req_if.sink    req_ch,
   sie_rsp_if.source  rsp_ch
);
   logic                          clear_ff, clear_in;
   logic [sie_pkg::MEM_AW-1:0]    clr_addr_ff, clr_addr_in;
   logic [sie_pkg::PC_W-1:0]      pc_ff, pc_in;
   logic [sie_pkg::NUM_REGS-1:0]  reg_vld_ff, reg_vld_in;

   logic                          s1_valid_ff, s1_valid_in;
   sie_pkg::item_type             s1_ff, s1_in;
   logic                          s2_valid_ff, s2_valid_in;
   sie_pkg::ex_type               s2_ff, s2_in;
   logic                          out_valid_ff, out_valid_in;
   sie_pkg::out_type              out_ff, out_in;

   logic                          wb_valid_ff, wb_valid_in;
   logic [sie_pkg::RIDX_W-1:0]    wb_rd_ff, wb_rd_in;
   logic [sie_pkg::DATA_W-1:0]    wb_val_ff, wb_val_in;

   logic out_free, s2_go, s2_free, s1_go, s1_free, accept;

   logic [sie_pkg::DATA_W-1:0] ra_rdata, rb_rdata, mem_rdata;
   logic [sie_pkg::DATA_W-1:0] s2_val, op_a, op_b, sum;
   logic                       in_range, lt_ab, lt_ba, taken, sw_hit;
   sie_pkg::ex_type            ex;

   logic                       reg_we;
   logic                       mem_we, mem_re;
   logic [sie_pkg::MEM_AW-1:0] mem_waddr;
   logic [sie_pkg::DATA_W-1:0] mem_wdata;

   // stage handshakes
   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign s2_go    = s2_valid_ff && out_free;
   assign s2_free  = !s2_valid_ff || s2_go;
   assign s1_go    = s1_valid_ff && s2_free;
   assign s1_free  = !s1_valid_ff || s1_go;
   assign req_ch.ready = s1_free && !clear_ff;
   assign accept   = req_ch.valid && req_ch.ready;

   // write-back value: load data arrives from the data ram in this stage
   assign s2_val = s2_ff.is_lw ? mem_rdata : s2_ff.val;
   assign reg_we = s2_go && s2_ff.wr;

   // register file, one copy per read port
   sie_ram #(.WIDTH(sie_pkg::DATA_W), .DEPTH(sie_pkg::NUM_REGS)) u_rf_a (
      .clock (clock),
      .we    (reg_we),
      .waddr (s2_ff.rd[sie_pkg::REG_AW-1:0]),
      .wdata (s2_val),
      .re    (accept),
      .raddr (req_ch.src_reg_a[sie_pkg::REG_AW-1:0]),
      .rdata (ra_rdata)
   );

   sie_ram #(.WIDTH(sie_pkg::DATA_W), .DEPTH(sie_pkg::NUM_REGS)) u_rf_b (
      .clock (clock),
      .we    (reg_we),
      .waddr (s2_ff.rd[sie_pkg::REG_AW-1:0]),
      .wdata (s2_val),
      .re    (accept),
      .raddr (req_ch.src_reg_b[sie_pkg::REG_AW-1:0]),
      .rdata (rb_rdata)
   );

   // operand forwarding: stage 2 is younger than the last committed write
   always_comb begin
      op_a = s1_ff.a_ok ? ra_rdata : '0;
      op_b = s1_ff.b_ok ? rb_rdata : '0;
      if (wb_valid_ff && wb_rd_ff == s1_ff.ra) begin
         op_a = wb_val_ff;
      end
      if (wb_valid_ff && wb_rd_ff == s1_ff.rb) begin
         op_b = wb_val_ff;
      end
      if (s2_valid_ff && s2_ff.wr && s2_ff.rd == s1_ff.ra) begin
         op_a = s2_val;
      end
      if (s2_valid_ff && s2_ff.wr && s2_ff.rd == s1_ff.rb) begin
         op_b = s2_val;
      end
   end

   // execute
   always_comb begin
      sum      = op_a + s1_ff.imm;
      in_range = sum < 32'(sie_pkg::MEM_WORDS);
      lt_ab    = $signed(op_a) < $signed(op_b);
      lt_ba    = $signed(op_b) < $signed(op_a);
      taken    = 1'b0;
      sw_hit   = 1'b0;
      ex       = '0;
      unique case (s1_ff.op)
         sie_pkg::OP_SUB: begin
            ex.val = op_a - op_b;
            ex.wr  = 1'b1;
         end
         sie_pkg::OP_ADDI: begin
            ex.val = sum;
            ex.wr  = 1'b1;
         end
         sie_pkg::OP_SUBI: begin
            ex.val = op_a - s1_ff.imm;
            ex.wr  = 1'b1;
         end
         sie_pkg::OP_LI: begin
            ex.val = s1_ff.imm;
            ex.wr  = 1'b1;
         end
         sie_pkg::OP_MV: begin
            ex.val = op_a;
            ex.wr  = 1'b1;
         end
         sie_pkg::OP_SLT: begin
            ex.val = {31'd0, lt_ab};
            ex.wr  = 1'b1;
         end
         sie_pkg::OP_LW: begin
            if (in_range) begin
               ex.is_lw = 1'b1;
               ex.wr    = 1'b1;
            end else begin
               ex.fault = 1'b1;
            end
         end
         sie_pkg::OP_SW: begin
            if (in_range) begin
               sw_hit = 1'b1;
               ex.val = op_b;
            end else begin
               ex.fault = 1'b1;
            end
         end
         sie_pkg::OP_J:    taken = 1'b1;
         sie_pkg::OP_BLT:  taken = lt_ab;
         sie_pkg::OP_BGT:  taken = lt_ba;
         sie_pkg::OP_BGE:  taken = !lt_ab;
         sie_pkg::OP_BNE:  taken = (op_a != op_b);
         sie_pkg::OP_EXIT: ex.halt = 1'b1;
         default: ;
      endcase
      // writes beyond the register file are dropped
      if (ex.wr && 32'(s1_ff.rd) >= 32'(sie_pkg::NUM_REGS)) begin
         ex.wr    = 1'b0;
         ex.is_lw = 1'b0;
         ex.val   = '0;
      end
      ex.rd = ex.wr ? s1_ff.rd : '0;
      if (ex.halt) begin
         ex.next_pc = pc_ff;
      end else if (taken && s1_ff.found) begin
         ex.next_pc = sie_pkg::clamp_pc(32'(s1_ff.tgt));
      end else begin
         ex.next_pc = sie_pkg::clamp_pc(32'(pc_ff) + 32'd1);
      end
   end

   // data memory: clearing sweep shares the write port with stores
   assign mem_we    = clear_ff || (s1_go && sw_hit);
   assign mem_waddr = clear_ff ? clr_addr_ff : sum[sie_pkg::MEM_AW-1:0];
   assign mem_wdata = clear_ff ? '0 : op_b;
   assign mem_re    = s1_go && ex.is_lw;

   sie_ram #(.WIDTH(sie_pkg::DATA_W), .DEPTH(sie_pkg::MEM_WORDS)) u_dmem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (sum[sie_pkg::MEM_AW-1:0]),
      .rdata (mem_rdata)
   );

   // next state
   always_comb begin
      clear_in    = clear_ff;
      clr_addr_in = clr_addr_ff;
      if (clear_ff) begin
         clr_addr_in = clr_addr_ff + sie_pkg::MEM_AW'(1);
         if (clr_addr_ff == sie_pkg::MEM_AW'(sie_pkg::MEM_WORDS - 1)) begin
            clear_in = 1'b0;
         end
      end

      reg_vld_in = reg_vld_ff;
      if (reg_we) begin
         reg_vld_in[s2_ff.rd[sie_pkg::REG_AW-1:0]] = 1'b1;
      end

      s1_valid_in = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
      s1_in       = s1_ff;
      if (accept) begin
         s1_in.op    = req_ch.opcode;
         s1_in.rd    = req_ch.dest_reg;
         s1_in.ra    = req_ch.src_reg_a;
         s1_in.rb    = req_ch.src_reg_b;
         s1_in.imm   = $unsigned(req_ch.immediate);
         s1_in.tgt   = req_ch.target_pc;
         s1_in.found = req_ch.target_found;
         // never-written registers read as zero
         s1_in.a_ok  = (32'(req_ch.src_reg_a) < 32'(sie_pkg::NUM_REGS)) &&
                       reg_vld_ff[req_ch.src_reg_a[sie_pkg::REG_AW-1:0]];
         s1_in.b_ok  = (32'(req_ch.src_reg_b) < 32'(sie_pkg::NUM_REGS)) &&
                       reg_vld_ff[req_ch.src_reg_b[sie_pkg::REG_AW-1:0]];
      end

      pc_in       = s1_go ? ex.next_pc : pc_ff;
      s2_valid_in = s1_go ? 1'b1 : (s2_go ? 1'b0 : s2_valid_ff);
      s2_in       = s1_go ? ex : s2_ff;

      wb_valid_in = reg_we ? 1'b1 : wb_valid_ff;
      wb_rd_in    = reg_we ? s2_ff.rd : wb_rd_ff;
      wb_val_in   = reg_we ? s2_val : wb_val_ff;

      out_valid_in = s2_go ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);
      out_in       = out_ff;
      if (s2_go) begin
         out_in.next_pc       = s2_ff.next_pc;
         out_in.reg_written   = s2_ff.wr;
         out_in.written_reg   = s2_ff.rd;
         out_in.written_value = s2_val;
         out_in.memory_fault  = s2_ff.fault;
         out_in.halted        = s2_ff.halt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clr_addr_ff  <= '0;
         pc_ff        <= '0;
         reg_vld_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         wb_valid_ff  <= 1'b0;
      end else begin
         clear_ff     <= clear_in;
         clr_addr_ff  <= clr_addr_in;
         pc_ff        <= pc_in;
         reg_vld_ff   <= reg_vld_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
         wb_valid_ff  <= wb_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff     <= s1_in;
      s2_ff     <= s2_in;
      out_ff    <= out_in;
      wb_rd_ff  <= wb_rd_in;
      wb_val_ff <= wb_val_in;
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.next_pc       = out_ff.next_pc;
   assign rsp_ch.reg_written   = out_ff.reg_written;
   assign rsp_ch.written_reg   = out_ff.written_reg;
   assign rsp_ch.written_value = $signed(out_ff.written_value);
   assign rsp_ch.memory_fault  = out_ff.memory_fault;
   assign rsp_ch.halted        = out_ff.halted;

   `ASSERT_IMPLY(a_no_accept_in_clear, clock, reset, clear_ff, !req_ch.ready)
   `ASSERT_IMPLY(a_commit_from_s2, clock, reset, reg_we, s2_valid_ff && out_free)
   `ASSERT_IMPLY(a_no_store_in_clear, clock, reset, clear_ff, !s1_valid_ff && !mem_re)
   `ASSERT_ALWAYS(a_pc_bound, clock, reset, 32'(pc_ff) <= 32'(sie_pkg::PROG_DEPTH))
   `ASSERT_NEXT(a_exit_keeps_pc, clock, reset, s1_go && ex.halt, pc_ff == $past(pc_ff))
   `ASSERT_IMPLY(a_write_no_fault, clock, reset, rsp_ch.valid && rsp_ch.reg_written, !rsp_ch.memory_fault)
endmodule
